FILE: design/pts_pkg.sv
// Shared types and constants for the periodic task scheduler.
// No dependencies; every other design file but pts_ram refers to it by scoped names.
package pts_pkg;

   localparam int TICK_W       = 32;
   localparam int NUM_SLOTS_DEF = 16;
   localparam int MAX_FIRES    = 16;

   localparam logic [2:0] OP_SCAN       = 3'd0;
   localparam logic [2:0] OP_REGISTER   = 3'd1;
   localparam logic [2:0] OP_UNREGISTER = 3'd2;
   localparam logic [2:0] OP_QUERY      = 3'd3;
   localparam logic [2:0] OP_RESET_CNT  = 3'd4;

   typedef struct packed {
      logic [2:0]        req_type;
      logic [3:0]        slot;
      logic [TICK_W-1:0] now_tick;
      logic [TICK_W-1:0] period_ticks;
      logic [TICK_W-1:0] first_delay;
      logic [TICK_W-1:0] run_limit;
   } req_item_type;

   typedef struct packed {
      logic              status;
      logic              fired;
      logic [3:0]        fired_slot;
      logic [TICK_W-1:0] elapsed_ticks;
      logic              last;
   } rsp_item_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;
      logic single_go;
      logic scan_run;
      logic finish_go;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic in_scan;
      logic out_free;
      logic scan_done;
   } ctl_stat_type;

endpackage

FILE: design/pts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/pts_ctrl.sv
// Request sequencer of the periodic task scheduler.
// Depends on pts_pkg for the command and status structs.
module pts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pts_pkg::ctl_stat_type stat,
   output pts_pkg::ctl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_ready_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_req = req_valid;
            if (req_valid) begin
               state_in = stat.in_scan ? ST_SCAN : ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.single_go = stat.out_free;
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish_go = stat.out_free;
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_ready = req_ready_ff;

endmodule

FILE: design/pts_dp.sv
// Datapath of the periodic task scheduler: slot stores, scan pipeline,
// pending-firing buffer and result register. Depends on pts_pkg and pts_ram.
module pts_dp #(
   parameter int NUM_SLOTS = pts_pkg::NUM_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pts_pkg::ctl_cmd_type  cmd,
   output pts_pkg::ctl_stat_type stat,
   input  pts_pkg::req_item_type req_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output pts_pkg::rsp_item_type rsp_data
);

   localparam int IdxW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CntW  = $clog2(NUM_SLOTS + 1);
   localparam int FireW = $clog2(pts_pkg::MAX_FIRES + 1);
   localparam int TW    = pts_pkg::TICK_W;

   typedef struct packed {
      logic [TW-1:0] period;
      logic [TW-1:0] start;
      logic [TW-1:0] delay;
      logic [TW-1:0] limit;
   } cfg_entry_type;

   typedef struct packed {
      logic [TW-1:0] last_run;
      logic [TW-1:0] count;
   } hist_entry_type;

   pts_pkg::req_item_type req_ff;
   logic [CntW-1:0]       idx_ff;
   logic                  ev_vld_ff;
   logic [IdxW-1:0]       ev_idx_ff;
   logic [FireW-1:0]      fire_cnt_ff;
   logic                  pend_vld_ff;
   logic [IdxW-1:0]       pend_slot_ff;
   logic [TW-1:0]         pend_elapsed_ff;
   logic [NUM_SLOTS-1:0]  flag_ff;
   logic [NUM_SLOTS-1:0]  lrt_vld_ff;
   logic [NUM_SLOTS-1:0]  cnt_vld_ff;
   logic                  rsp_vld_ff;
   pts_pkg::rsp_item_type rsp_ff;

   cfg_entry_type  cfg_wr;
   cfg_entry_type  cfg_rd;
   hist_entry_type hist_wr;
   hist_entry_type hist_rd;
   logic           cfg_we;

   logic            slot_ok;
   logic [IdxW-1:0] slot_addr;
   logic            slot_reg;
   logic            single_st;

   logic [TW-1:0] cur_last;
   logic [TW-1:0] cur_cnt;
   logic [TW-1:0] due;
   logic [TW-1:0] elapsed;
   logic [TW-1:0] cnt_inc;
   logic          ev_fire;
   logic          out_free;
   logic          ev_stall;
   logic          scan_issue;
   logic          fire_take;
   logic          out_load;
   pts_pkg::rsp_item_type out_next;

   // ---- single-slot requests
   assign slot_ok   = 32'(req_ff.slot) < 32'(NUM_SLOTS);
   assign slot_addr = IdxW'(req_ff.slot);
   assign slot_reg  = slot_ok && flag_ff[slot_addr];

   always_comb begin
      unique case (req_ff.req_type)
         pts_pkg::OP_REGISTER:   single_st = !slot_ok;
         pts_pkg::OP_UNREGISTER: single_st = !slot_reg;
         pts_pkg::OP_QUERY:      single_st = !slot_reg;
         pts_pkg::OP_RESET_CNT:  single_st = !slot_ok;
         default:                single_st = 1'b1;
      endcase
   end

   assign cfg_we        = cmd.single_go && (req_ff.req_type == pts_pkg::OP_REGISTER) && slot_ok;
   assign cfg_wr.period = (req_ff.period_ticks == '0) ? TW'(1) : req_ff.period_ticks;
   assign cfg_wr.start  = req_ff.now_tick;
   assign cfg_wr.delay  = req_ff.first_delay;
   assign cfg_wr.limit  = req_ff.run_limit;

   // ---- scan evaluation; history words never written read as zero
   assign cur_last = lrt_vld_ff[ev_idx_ff] ? hist_rd.last_run : '0;
   assign cur_cnt  = cnt_vld_ff[ev_idx_ff] ? hist_rd.count : '0;
   assign due      = cfg_rd.start + cfg_rd.delay;
   assign elapsed  = req_ff.now_tick - cur_last;
   assign cnt_inc  = cur_cnt + TW'(1);

   assign ev_fire = ev_vld_ff && flag_ff[ev_idx_ff]
                 && (req_ff.now_tick >= due)
                 && (cur_cnt < cfg_rd.limit)
                 && (elapsed >= cfg_rd.period)
                 && (fire_cnt_ff < FireW'(pts_pkg::MAX_FIRES));

   // late slot resyncs to now, on-time slot advances by one period
   assign hist_wr.last_run = (elapsed > cfg_rd.period) ? req_ff.now_tick
                                                       : cur_last + cfg_rd.period;
   assign hist_wr.count    = (cnt_inc == '1) ? '0 : cnt_inc;

   assign out_free   = !rsp_vld_ff || rsp_ready;
   // a second firing needs the pending one moved out first
   assign ev_stall   = ev_fire && pend_vld_ff && !out_free;
   assign scan_issue = cmd.scan_run && !ev_stall && (idx_ff < CntW'(NUM_SLOTS));
   assign fire_take  = cmd.scan_run && ev_fire && !ev_stall;

   pts_ram #(
      .WIDTH ($bits(cfg_entry_type)),
      .DEPTH (NUM_SLOTS)
   ) u_cfg_ram (
      .clock   (clock),
      .wr_en   (cfg_we),
      .wr_addr (slot_addr),
      .wr_data (cfg_wr),
      .rd_en   (scan_issue),
      .rd_addr (idx_ff[IdxW-1:0]),
      .rd_data (cfg_rd)
   );

   pts_ram #(
      .WIDTH ($bits(hist_entry_type)),
      .DEPTH (NUM_SLOTS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (fire_take),
      .wr_addr (ev_idx_ff),
      .wr_data (hist_wr),
      .rd_en   (scan_issue),
      .rd_addr (idx_ff[IdxW-1:0]),
      .rd_data (hist_rd)
   );

   // ---- result select
   assign out_load = cmd.single_go || cmd.finish_go || (fire_take && pend_vld_ff);

   always_comb begin
      out_next = '0;
      out_next.last = 1'b1;
      priority if (fire_take) begin
         out_next.fired         = 1'b1;
         out_next.fired_slot    = 4'(pend_slot_ff);
         out_next.elapsed_ticks = pend_elapsed_ff;
         out_next.last          = 1'b0;
      end else if (cmd.finish_go && pend_vld_ff) begin
         out_next.fired         = 1'b1;
         out_next.fired_slot    = 4'(pend_slot_ff);
         out_next.elapsed_ticks = pend_elapsed_ff;
      end else if (cmd.finish_go) begin
         out_next.status = 1'b1;
      end else begin
         out_next.status = single_st;
      end
   end

   // ---- control state
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         ev_vld_ff   <= 1'b0;
         fire_cnt_ff <= '0;
         pend_vld_ff <= 1'b0;
         flag_ff     <= '0;
         lrt_vld_ff  <= '0;
         cnt_vld_ff  <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (cmd.load_req) begin
            idx_ff      <= '0;
            ev_vld_ff   <= 1'b0;
            fire_cnt_ff <= '0;
            pend_vld_ff <= 1'b0;
         end
         if (cmd.scan_run && !ev_stall) begin
            ev_vld_ff <= scan_issue;
            if (scan_issue) begin
               idx_ff <= idx_ff + CntW'(1);
            end
         end
         if (fire_take) begin
            fire_cnt_ff           <= fire_cnt_ff + FireW'(1);
            pend_vld_ff           <= 1'b1;
            lrt_vld_ff[ev_idx_ff] <= 1'b1;
            cnt_vld_ff[ev_idx_ff] <= 1'b1;
         end
         if (cmd.finish_go) begin
            pend_vld_ff <= 1'b0;
         end
         if (cmd.single_go) begin
            unique case (req_ff.req_type)
               pts_pkg::OP_REGISTER: begin
                  if (slot_ok) begin
                     flag_ff[slot_addr] <= 1'b1;
                  end
               end
               pts_pkg::OP_UNREGISTER: begin
                  if (slot_reg) begin
                     flag_ff[slot_addr]    <= 1'b0;
                     cnt_vld_ff[slot_addr] <= 1'b0;
                  end
               end
               pts_pkg::OP_RESET_CNT: begin
                  if (slot_ok) begin
                     cnt_vld_ff[slot_addr] <= 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         if (out_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // ---- payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.scan_run && !ev_stall) begin
         ev_idx_ff <= idx_ff[IdxW-1:0];
      end
      if (fire_take) begin
         pend_slot_ff    <= ev_idx_ff;
         pend_elapsed_ff <= elapsed;
      end
      if (out_load) begin
         rsp_ff <= out_next;
      end
   end

   assign stat.in_scan   = (req_data.req_type == pts_pkg::OP_SCAN);
   assign stat.out_free  = out_free;
   assign stat.scan_done = (idx_ff == CntW'(NUM_SLOTS)) && !ev_vld_ff;

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: design/periodic_task_scheduler.sv
// Periodic task scheduler: a scan walks the slot table one slot per cycle through
// a read stage and an evaluate stage, unless a firing waits on a full result register.
// One request at a time; a full result register may wait while the next request is
// accepted. Synchronous active-high reset clears control state and all slot flags;
// stored counts and last-run ticks read as zero until written.
module periodic_task_scheduler #(
   parameter int NUM_SLOTS = pts_pkg::NUM_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pts_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pts_pkg::rsp_item_type rsp_data
);

   pts_pkg::ctl_cmd_type  cmd;
   pts_pkg::ctl_stat_type stat;

   pts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pts_dp #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: design/pts_checker.sv
// Port-level checks for the periodic task scheduler, bound to the top level.
// Depends on pts_pkg and periodic_task_scheduler.
module pts_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input pts_pkg::req_item_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input pts_pkg::rsp_item_type rsp_data
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_fire_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fired |-> !rsp_data.status)
      else $error("firing beat with nonzero status");

   a_nofire_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.fired |->
         rsp_data.last && rsp_data.fired_slot == 4'd0 && rsp_data.elapsed_ticks == '0)
      else $error("non-firing beat not final or not cleared");

   // one request in flight at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while one in flight");

endmodule

bind periodic_task_scheduler pts_checker u_pts_checker (.*);

FILE: sim/tb_periodic_task_scheduler.sv
`timescale 1ns / 100ps
// Self-checking bench for periodic_task_scheduler: a shadow slot table works out the
// answer beats of every accepted request. Depends on pts_pkg and the scheduler RTL.
module tb_periodic_task_scheduler;

   localparam int          SLOT_COUNT  = 16;
   localparam int          CYCLE_LIMIT = 600000;
   localparam int          DRAIN_WAIT  = 40;
   localparam int          HOLD_CYCLES = 300;
   localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
   localparam logic        ST_DONE     = 1'b0;
   localparam logic        ST_MISS     = 1'b1;
   localparam logic [2:0]  OP_RSVD_5   = 3'd5;
   localparam logic [2:0]  OP_RSVD_6   = 3'd6;
   localparam logic [2:0]  OP_RSVD_7   = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   pts_pkg::req_item_type req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   pts_pkg::rsp_item_type rsp_data;

   // shadow of the slot table
   logic        tbl_live     [SLOT_COUNT];
   logic [31:0] tbl_period   [SLOT_COUNT];
   logic [31:0] tbl_start    [SLOT_COUNT];
   logic [31:0] tbl_delay    [SLOT_COUNT];
   logic [31:0] tbl_limit    [SLOT_COUNT];
   logic [31:0] tbl_last_run [SLOT_COUNT];
   logic [31:0] tbl_runs     [SLOT_COUNT];

   pts_pkg::rsp_item_type sched_answers[$];
   int           fail_count;
   int           cycle_count;
   int           sink_hold_reqs;
   bit           send_gaps_on;
   bit           sink_stalls_on;
   logic [31:0]  tick_now;

   periodic_task_scheduler #(.NUM_SLOTS(SLOT_COUNT)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("periodic_task_scheduler test failed");
         $finish;
      end
   end

   function automatic pts_pkg::req_item_type make_req(logic [2:0] op, logic [3:0] slot,
                                                      logic [31:0] now, logic [31:0] per,
                                                      logic [31:0] dly, logic [31:0] lim);
      pts_pkg::req_item_type r;
      r.req_type     = op;
      r.slot         = slot;
      r.now_tick     = now;
      r.period_ticks = per;
      r.first_delay  = dly;
      r.run_limit    = lim;
      return r;
   endfunction

   // Apply one request to the shadow table and queue the beats it answers with.
   task automatic apply_request(pts_pkg::req_item_type r);
      pts_pkg::rsp_item_type beat;
      pts_pkg::rsp_item_type held;
      bit           have_held;
      int           i;
      logic [31:0]  due;
      logic [31:0]  gap;
      beat      = '0;
      beat.last = 1'b1;
      beat.status = ST_MISS;
      have_held = 1'b0;
      held      = '0;
      case (r.req_type)
         pts_pkg::OP_SCAN: begin
            for (i = 0; i < SLOT_COUNT; i++) begin
               due = tbl_start[i] + tbl_delay[i];
               gap = r.now_tick - tbl_last_run[i];
               if (tbl_live[i] && r.now_tick >= due && tbl_runs[i] < tbl_limit[i] &&
                   gap >= tbl_period[i]) begin
                  // late slots resync to now, on-time slots advance one period
                  if (gap > tbl_period[i]) tbl_last_run[i] = r.now_tick;
                  else tbl_last_run[i] = tbl_last_run[i] + tbl_period[i];
                  tbl_runs[i] = tbl_runs[i] + 1;
                  if (tbl_runs[i] == ALL_ONES) tbl_runs[i] = '0;
                  if (have_held) sched_answers.push_back(held);
                  held               = '0;
                  held.status        = ST_DONE;
                  held.fired         = 1'b1;
                  held.fired_slot    = i[3:0];
                  held.elapsed_ticks = gap;
                  have_held          = 1'b1;
               end
            end
            if (have_held) begin
               held.last = 1'b1;
               beat      = held;
            end
         end
         pts_pkg::OP_REGISTER: begin
            tbl_start[r.slot]  = r.now_tick;
            tbl_period[r.slot] = (r.period_ticks == '0) ? 32'd1 : r.period_ticks;
            tbl_delay[r.slot]  = r.first_delay;
            tbl_limit[r.slot]  = r.run_limit;
            tbl_live[r.slot]   = 1'b1;
            beat.status        = ST_DONE;
         end
         pts_pkg::OP_UNREGISTER: begin
            if (tbl_live[r.slot]) begin
               tbl_live[r.slot] = 1'b0;
               tbl_runs[r.slot] = '0;
               beat.status      = ST_DONE;
            end
         end
         pts_pkg::OP_QUERY: begin
            if (tbl_live[r.slot]) beat.status = ST_DONE;
         end
         pts_pkg::OP_RESET_CNT: begin
            tbl_runs[r.slot] = '0;
            beat.status      = ST_DONE;
         end
         default: begin
         end
      endcase
      sched_answers.push_back(beat);
   endtask

   // Offer one request beat; entered and left at a rising edge, valid left high.
   task automatic send_req(pts_pkg::req_item_type r);
      int gap;
      gap = send_gaps_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      apply_request(r);
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin : rsp_sink
      int stall;
      int holds_done;
      holds_done = 0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = sink_stalls_on ? $urandom_range(0, 9) : 0;
         if (sink_hold_reqs != holds_done) begin
            stall      = HOLD_CYCLES;
            holds_done = sink_hold_reqs;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin : rsp_check
      pts_pkg::rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (sched_answers.size() == 0) begin
            $error("unexpected result beat: status %0b fired %0b slot %0d elapsed %0h",
                   rsp_data.status, rsp_data.fired, rsp_data.fired_slot,
                   rsp_data.elapsed_ticks);
            fail_count++;
         end else begin
            want = sched_answers.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0b, got %0b", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.fired !== want.fired) begin
               $error("fired: expected %0b, got %0b", want.fired, rsp_data.fired);
               fail_count++;
            end
            if (rsp_data.fired_slot !== want.fired_slot) begin
               $error("fired_slot: expected %0d, got %0d", want.fired_slot,
                      rsp_data.fired_slot);
               fail_count++;
            end
            if (rsp_data.elapsed_ticks !== want.elapsed_ticks) begin
               $error("elapsed_ticks: expected %0h, got %0h", want.elapsed_ticks,
                      rsp_data.elapsed_ticks);
               fail_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_data.last);
               fail_count++;
            end
         end
      end
   end

   // commands on empty slots and the reserved request types
   task automatic test_slot_commands();
      send_req(make_req(pts_pkg::OP_QUERY, 4'd0, '0, '0, '0, '0));
      send_req(make_req(pts_pkg::OP_SCAN, 4'd0, '0, '0, '0, '0));
      send_req(make_req(pts_pkg::OP_UNREGISTER, 4'd5, '0, '0, '0, '0));
      send_req(make_req(pts_pkg::OP_RESET_CNT, 4'd7, '0, '0, '0, '0));
      send_req(make_req(OP_RSVD_5, 4'd15, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
      send_req(make_req(OP_RSVD_6, 4'd1, '0, '0, '0, '0));
      send_req(make_req(OP_RSVD_7, 4'd2, 32'h1234, 32'h5, 32'h6, 32'h7));
   endtask

   // period zero, wrapped delay sum, late and on-time firing, run limit, re-register
   task automatic test_scan_timing();
      send_req(make_req(pts_pkg::OP_REGISTER, 4'd0, 32'd100, '0, '0, ALL_ONES));
      send_req(make_req(pts_pkg::OP_REGISTER, 4'd15, ALL_ONES, ALL_ONES, ALL_ONES, 32'd3));
      send_req(make_req(pts_pkg::OP_REGISTER, 4'd3, 32'hFFFF_FFF0, 32'd10, 32'h20, 32'd2));
      send_req(make_req(pts_pkg::OP_QUERY, 4'd0, '0, '0, '0, '0));
      send_req(make_req(pts_pkg::OP_SCAN, 4'd0, 32'd101, '0, '0, '0));
      send_req(make_req(pts_pkg::OP_SCAN, 4'd0, 32'd102, '0, '0, '0));
      send_req(make_req(pts_pkg::OP_SCAN, 4'd0, 32'd111, '0, '0, '0));
      send_req(make_req(pts_pkg::OP_SCAN, 4'd0, 32'd200, '0, '0, '0));
      send_req(make_req(pts_pkg::OP_RESET_CNT, 4'd3, '0, '0, '0, '0));
      send_req(make_req(pts_pkg::OP_SCAN, 4'd0, 32'd300, '0, '0, '0));
      send_req(make_req(pts_pkg::OP_REGISTER, 4'd0, 32'd300, 32'd5, '0, 32'd1));
      send_req(make_req(pts_pkg::OP_SCAN, 4'd0, ALL_ONES, '0, '0, '0));
      send_req(make_req(pts_pkg::OP_UNREGISTER, 4'd3, '0, '0, '0, '0));
      send_req(make_req(pts_pkg::OP_QUERY, 4'd3, '0, '0, '0, '0));
      tick_now = 32'd1000;
   endtask

   // hold the result side off while requests keep coming, so the input stalls
   task automatic test_input_stall();
      int n;
      send_gaps_on   = 1'b0;
      sink_hold_reqs = sink_hold_reqs + 1;
      for (n = 0; n < 12; n++) begin
         tick_now = tick_now + 7;
         if (n[0]) send_req(make_req(pts_pkg::OP_SCAN, '0, tick_now, '0, '0, '0));
         else send_req(make_req(pts_pkg::OP_QUERY, n[3:0], '0, '0, '0, '0));
      end
      send_gaps_on = 1'b1;
   endtask

   task automatic test_random_traffic(int item_total);
      int          sent;
      int          pick;
      int          s;
      logic [31:0] per;
      logic [31:0] dly;
      logic [31:0] lim;
      pts_pkg::req_item_type r;
      // fill every slot, then one scan after every slot's first delay has passed
      for (s = 0; s < SLOT_COUNT; s++) begin
         lim = $urandom_range(0, 1) ? ALL_ONES : 32'($urandom_range(1, 8));
         send_req(make_req(pts_pkg::OP_REGISTER, s[3:0], tick_now,
                           32'($urandom_range(1, 20)), 32'($urandom_range(0, 20)), lim));
      end
      tick_now = tick_now + 100;
      send_req(make_req(pts_pkg::OP_SCAN, '0, tick_now, '0, '0, '0));
      sent = 0;
      while (sent < item_total) begin
         if (sent % 60 == 0) begin
            send_gaps_on   = ((sent / 60) % 3 != 2) && ($urandom_range(0, 3) != 0);
            sink_stalls_on = ((sent / 60) % 3 != 2) && ($urandom_range(0, 3) != 0);
         end
         pick = $urandom_range(0, 99);
         r    = make_req(pts_pkg::OP_SCAN, 4'($urandom_range(0, 15)), tick_now, '0, '0, '0);
         if (pick < 50) begin
            if ($urandom_range(0, 19) == 0) tick_now = tick_now + $urandom;
            else tick_now = tick_now + $urandom_range(0, 40);
            r.now_tick = tick_now;
         end else if (pick < 70) begin
            case ($urandom_range(0, 9))
               0:       per = '0;
               1:       per = $urandom;
               default: per = $urandom_range(1, 40);
            endcase
            dly = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 60));
            case ($urandom_range(0, 9))
               0:       lim = ALL_ONES;
               1:       lim = $urandom;
               2:       lim = '0;
               default: lim = $urandom_range(1, 6);
            endcase
            r = make_req(pts_pkg::OP_REGISTER, r.slot, tick_now, per, dly, lim);
         end else if (pick < 78) begin
            r.req_type = pts_pkg::OP_UNREGISTER;
         end else if (pick < 84) begin
            r.req_type = pts_pkg::OP_QUERY;
         end else if (pick < 90) begin
            r.req_type = pts_pkg::OP_RESET_CNT;
         end else if (pick < 95) begin
            r = make_req(3'($urandom_range(0, 7)), 4'($urandom), $urandom, $urandom,
                         $urandom, $urandom);
         end else begin
            r.now_tick = $urandom;
         end
         send_req(r);
         if (r.req_type <= pts_pkg::OP_RESET_CNT) sent++;
      end
      send_gaps_on   = 1'b1;
      sink_stalls_on = 1'b1;
   endtask

   initial begin : main_seq
      int i;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_data         <= '0;
      send_gaps_on     = 1'b1;
      sink_stalls_on   = 1'b1;
      tick_now         = '0;
      for (i = 0; i < SLOT_COUNT; i++) begin
         tbl_live[i]     = 1'b0;
         tbl_period[i]   = '0;
         tbl_start[i]    = '0;
         tbl_delay[i]    = '0;
         tbl_limit[i]    = '0;
         tbl_last_run[i] = '0;
         tbl_runs[i]     = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_slot_commands();
      test_scan_timing();
      test_input_stall();
      test_random_traffic(310);

      req_valid <= 1'b0;
      while (sched_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("periodic_task_scheduler test passed");
      end else begin
         $display("periodic_task_scheduler test failed");
      end
      $finish;
   end

endmodule

FILE: periodic_task_scheduler.f
design/pts_pkg.sv
design/pts_ram.sv
design/pts_ctrl.sv
design/pts_dp.sv
design/periodic_task_scheduler.sv
design/pts_checker.sv
sim/tb_periodic_task_scheduler.sv
